>>> hw/rtl/rhcb_pkg.sv
// Shared types and fixed constants for the rolling hash chunk boundary block.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package rhcb_pkg;

   // Field widths
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 32;

   // Cut when the rolling value mod CUT_MODULUS is CUT_MODULUS-1
   localparam int unsigned CUT_MODULUS = 64;
   localparam int unsigned CUT_BITS    = $clog2(CUT_MODULUS);

   // Left shift of the shift-xor term per hashed byte
   localparam int unsigned SHIFT_BITS = 5;

   // One staged input beat
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              stream_start;
   } item_type;

   // One result beat
   typedef struct packed {
      logic [WORD_W-1:0] byte_position;
      logic              was_hashed;
      logic [WORD_W-1:0] rolling_value;
      logic              chunk_done;
      logic              chunk_is_tail;
      logic [WORD_W-1:0] chunk_first;
      logic              stream_done;
   } result_type;

endpackage

`default_nettype wire

>>> hw/rtl/rhcb_req_if.sv
// Request channel: one stream byte per beat with a start-of-stream flag.
// Depends on rhcb_pkg for field widths.
`default_nettype none

interface rhcb_req_if;
   logic                           valid;
   logic                           ready;
   logic [rhcb_pkg::BYTE_W-1:0]    data_byte;
   logic                           stream_start;

   modport source (output valid, output data_byte, output stream_start, input ready);
   modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rhcb_rsp_if.sv
// Response channel: position, hash value and chunk marks per beat.
// Depends on rhcb_pkg for field widths.
`default_nettype none

interface rhcb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rhcb_pkg::WORD_W-1:0]    byte_position;
   logic                           was_hashed;
   logic [rhcb_pkg::WORD_W-1:0]    rolling_value;
   logic                           chunk_done;
   logic                           chunk_is_tail;
   logic [rhcb_pkg::WORD_W-1:0]    chunk_first;
   logic                           stream_done;

   modport source (output valid, output byte_position, output was_hashed,
                   output rolling_value, output chunk_done, output chunk_is_tail,
                   output chunk_first, output stream_done, input ready);
   modport sink   (input valid, input byte_position, input was_hashed,
                   input rolling_value, input chunk_done, input chunk_is_tail,
                   input chunk_first, input stream_done, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rhcb_window.sv
// Byte window of the rolling hash as a shift line; the oldest byte leaves at the end.
// Depends on rhcb_pkg for the byte width.
`default_nettype none

module rhcb_window #(
   parameter int unsigned WINDOW_LEN = 7
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           clear,
   input  wire                           shift,
   input  wire [rhcb_pkg::BYTE_W-1:0]    byte_in,
   output logic [rhcb_pkg::BYTE_W-1:0]   oldest
);

   logic [rhcb_pkg::BYTE_W-1:0] taps_ff [WINDOW_LEN];
   logic [rhcb_pkg::BYTE_W-1:0] taps_in [WINDOW_LEN];

   // Byte that leaves the window if this beat is hashed
   assign oldest = clear ? '0 : taps_ff[WINDOW_LEN-1];

   // Clear on stream start, then shift in the hashed byte
   always_comb begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
         taps_in[k] = clear ? '0 : taps_ff[k];
      end
      if (shift) begin
         taps_in[0] = byte_in;
         for (int k = 1; k < WINDOW_LEN; k++) begin
            taps_in[k] = clear ? '0 : taps_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_LEN; k++) begin
            taps_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < WINDOW_LEN; k++) begin
            taps_ff[k] <= taps_in[k];
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/rhcb_core.sv
// Hash state and its combinational update: sums, position, chunk start and skip count.
// Depends on rhcb_pkg and rhcb_window.
`default_nettype none

module rhcb_core #(
   parameter int unsigned WINDOW_LEN = 7,
   parameter int unsigned SKIP_COUNT = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           advance,
   input  rhcb_pkg::item_type            item,
   input  wire [rhcb_pkg::WORD_W-1:0]    stream_length,
   output rhcb_pkg::result_type          result
);

   localparam int unsigned SKIP_W = (SKIP_COUNT > 0) ? $clog2(SKIP_COUNT + 1) : 1;
   localparam int unsigned W      = rhcb_pkg::WORD_W;

   logic [W-1:0]      plain_ff, plain_in;
   logic [W-1:0]      weighted_ff, weighted_in;
   logic [W-1:0]      sxor_ff, sxor_in;
   logic [W-1:0]      position_ff, position_in;
   logic [W-1:0]      begin_ff, begin_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;

   logic [W-1:0]      cur_plain, cur_weighted, cur_sxor, cur_pos, cur_begin;
   logic [SKIP_W-1:0] cur_skip;
   logic [W-1:0]      sdata;
   logic [rhcb_pkg::BYTE_W-1:0] oldest;
   logic              hashed, cut, last, skip_start;
   logic [W-1:0]      rolling;
   logic [W:0]        pos_ext;

   // Window of hashed bytes
   rhcb_window #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .clear   (advance & item.stream_start),
      .shift   (advance & hashed),
      .byte_in (item.data_byte),
      .oldest  (oldest)
   );

   // Stream start clears the state seen by this byte
   always_comb begin
      cur_plain    = item.stream_start ? '0 : plain_ff;
      cur_weighted = item.stream_start ? '0 : weighted_ff;
      cur_sxor     = item.stream_start ? '0 : sxor_ff;
      cur_pos      = item.stream_start ? '0 : position_ff;
      cur_begin    = item.stream_start ? '0 : begin_ff;
      cur_skip     = item.stream_start ? '0 : skip_ff;
   end

   // Sign-extend the byte for the sums
   assign sdata   = {{(W - rhcb_pkg::BYTE_W){item.data_byte[rhcb_pkg::BYTE_W-1]}},
                     item.data_byte};
   assign hashed  = (cur_skip == '0);
   assign pos_ext = {1'b0, cur_pos};
   assign last    = (pos_ext + (W+1)'(1)) == {1'b0, stream_length};
   assign skip_start = (pos_ext + (W+1)'(SKIP_COUNT)) < {1'b0, stream_length};

   // Update the three hash terms
   always_comb begin
      if (hashed) begin
         weighted_in = cur_weighted - cur_plain + (sdata * W'(WINDOW_LEN));
         plain_in    = cur_plain + sdata - {{(W - rhcb_pkg::BYTE_W){1'b0}}, oldest};
         sxor_in     = (cur_sxor << rhcb_pkg::SHIFT_BITS) ^ sdata;
      end else begin
         weighted_in = cur_weighted;
         plain_in    = cur_plain;
         sxor_in     = cur_sxor;
      end
   end

   assign rolling = plain_in + weighted_in + sxor_in;
   assign cut     = hashed && (rolling[rhcb_pkg::CUT_BITS-1:0] == '1);

   // Chunk bookkeeping and skip count
   always_comb begin
      position_in = cur_pos + W'(1);
      begin_in    = (cut || last) ? cur_pos + W'(1) : cur_begin;
      if (cut && skip_start) begin
         skip_in = SKIP_W'(SKIP_COUNT);
      end else if (!hashed) begin
         skip_in = cur_skip - SKIP_W'(1);
      end else begin
         skip_in = cur_skip;
      end
   end

   // Assemble the result beat
   always_comb begin
      result.byte_position = cur_pos;
      result.was_hashed    = hashed;
      result.rolling_value = rolling;
      result.chunk_done    = cut || last;
      result.chunk_is_tail = !cut && last;
      result.chunk_first   = (cut || last) ? cur_begin : '0;
      result.stream_done   = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plain_ff    <= '0;
         weighted_ff <= '0;
         sxor_ff     <= '0;
         position_ff <= '0;
         begin_ff    <= '0;
         skip_ff     <= '0;
      end else if (advance) begin
         plain_ff    <= plain_in;
         weighted_ff <= weighted_in;
         sxor_ff     <= sxor_in;
         position_ff <= position_in;
         begin_ff    <= begin_in;
         skip_ff     <= skip_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/rolling_hash_chunk_boundary_top.sv
// Rolling hash chunk boundary finder: one stream byte per beat, one result per byte.
// An accepted byte is loaded into the input register; its hash update is loaded into
// the result register once that register is free, and the result register shows it.
// Throughput: one byte per cycle while rsp_bus.ready holds, set by the hash state update
// that each byte feeds to the next. Reset clears the pipeline and all hash state, stream_length is 1.
// Depends on rhcb_pkg, rhcb_req_if, rhcb_rsp_if, rhcb_window and rhcb_core.
`default_nettype none

module rolling_hash_chunk_boundary_top #(
   parameter int unsigned WINDOW_LEN = 7,
   parameter int unsigned SKIP_COUNT = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   rhcb_req_if.sink                      req_bus,
   rhcb_rsp_if.source                    rsp_bus,
   input  wire                           csr_write_enable,
   input  wire [rhcb_pkg::WORD_W-1:0]    csr_write_data
);

   logic [rhcb_pkg::WORD_W-1:0] length_ff;
   logic                        s1_valid_ff, s1_valid_in;
   rhcb_pkg::item_type          s1_item_ff;
   logic                        out_valid_ff, out_valid_in;
   rhcb_pkg::result_type        out_ff;
   rhcb_pkg::result_type        result;
   logic                        out_free, advance, req_take;

   // Stream length register
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= rhcb_pkg::WORD_W'(1);
      end else if (csr_write_enable) begin
         length_ff <= csr_write_data;
      end
   end

   // Handshake: advance the staged beat whenever the result register frees up
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign advance       = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.data_byte    <= req_bus.data_byte;
         s1_item_ff.stream_start <= req_bus.stream_start;
      end
   end

   rhcb_core #(
      .WINDOW_LEN (WINDOW_LEN),
      .SKIP_COUNT (SKIP_COUNT)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (s1_item_ff),
      .stream_length (length_ff),
      .result        (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.byte_position = out_ff.byte_position;
   assign rsp_bus.was_hashed    = out_ff.was_hashed;
   assign rsp_bus.rolling_value = out_ff.rolling_value;
   assign rsp_bus.chunk_done    = out_ff.chunk_done;
   assign rsp_bus.chunk_is_tail = out_ff.chunk_is_tail;
   assign rsp_bus.chunk_first   = out_ff.chunk_first;
   assign rsp_bus.stream_done   = out_ff.stream_done;

   // The last byte of a stream always closes a chunk
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.stream_done |-> out_ff.chunk_done)
      else $error("last byte without chunk end");

   // A tail chunk only ends on the last byte
   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.chunk_is_tail |-> out_ff.chunk_done && out_ff.stream_done)
      else $error("tail chunk off the last byte");

   // A skipped byte never makes a content cut
   a_skip_no_cut: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.was_hashed |-> !out_ff.chunk_done || out_ff.chunk_is_tail)
      else $error("cut on a skipped byte");

   // A staged beat blocked by a full result register stays staged
   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff)
      else $error("staged beat dropped");

endmodule

`default_nettype wire
